FILE: rtl/p2tl_pkg.sv
// shared types and constants of the primitive to triangle list converter
package p2tl_pkg;

  localparam int unsigned MAT_BITS   = 11;
  localparam int unsigned TYPE_BITS  = 2;
  localparam int unsigned SEEN_BITS  = 2;
  localparam int unsigned PHASE_BITS = 2;

  localparam logic [TYPE_BITS-1:0] PRIM_LIST  = 2'd0;
  localparam logic [TYPE_BITS-1:0] PRIM_STRIP = 2'd1;
  localparam logic [TYPE_BITS-1:0] PRIM_FAN   = 2'd2;

  localparam logic KIND_TRIANGLE = 1'b0;
  localparam logic KIND_RECORD   = 1'b1;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

FILE: rtl/p2tl_assemble.sv
// triangle assembly, degenerate culling and group record merging
module p2tl_assemble #(
  parameter int unsigned INDEX_BITS   = 16,
  parameter int unsigned COUNT_BITS   = 24,
  parameter int unsigned MAX_MATERIAL = 1024,
  localparam int unsigned RES_BITS    = 3 * INDEX_BITS + p2tl_pkg::MAT_BITS
                                        + 2 * COUNT_BITS + 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic [INDEX_BITS-1:0]          vertex_index_i,
  input  logic [p2tl_pkg::TYPE_BITS-1:0] prim_type_i,
  input  logic [p2tl_pkg::MAT_BITS-1:0]  material_id_i,
  input  logic                           group_end_i,
  output p2tl_pkg::push_t                push_o,
  output logic [RES_BITS-1:0]            first_o,
  output logic [RES_BITS-1:0]            second_o
);
  import p2tl_pkg::*;

  typedef struct packed {
    logic                  kind;
    logic [INDEX_BITS-1:0] corner_a;
    logic [INDEX_BITS-1:0] corner_b;
    logic [INDEX_BITS-1:0] corner_c;
    logic [MAT_BITS-1:0]   material;
    logic [COUNT_BITS-1:0] base;
    logic [COUNT_BITS-1:0] count;
    logic                  merged;
    logic                  last;
  } res_t;

  localparam logic [MAT_BITS+1:0] MatLimit = (MAT_BITS + 2)'(MAX_MATERIAL);

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] x,
                                                    input logic [COUNT_BITS-1:0] y);
    logic [COUNT_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  logic [INDEX_BITS-1:0] anchor_q, anchor_d;
  logic [INDEX_BITS-1:0] older_q, older_d;
  logic [INDEX_BITS-1:0] newer_q, newer_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic                  parity_q, parity_d;
  logic [SEEN_BITS-1:0]  seen_q, seen_d;
  logic [COUNT_BITS-1:0] group_cnt_q, group_cnt_d;
  logic [COUNT_BITS-1:0] total_cnt_q, total_cnt_d;
  logic                  prev_valid_q, prev_valid_d;
  logic [MAT_BITS-1:0]   prev_mat_q, prev_mat_d;
  logic [COUNT_BITS-1:0] prev_base_q, prev_base_d;
  logic [COUNT_BITS-1:0] prev_cnt_q, prev_cnt_d;

  logic                  mat_ok;
  logic                  tri_raw, tri_ok, rec_ok, merge;
  logic [INDEX_BITS-1:0] anchor_eff, corner_a, corner_b;
  logic [COUNT_BITS-1:0] group_after, rec_base, rec_cnt;
  res_t                  tri_r, rec_r, first_r, second_r;

  assign mat_ok     = {2'b00, material_id_i} <= MatLimit;
  assign anchor_eff = (seen_q == '0) ? vertex_index_i : anchor_q;

  always_comb begin
    tri_raw  = 1'b0;
    corner_a = '0;
    corner_b = '0;
    phase_d  = phase_q;
    parity_d = parity_q;
    case (prim_type_i)
      PRIM_LIST: begin
        if (phase_q == PHASE_BITS'(2)) begin
          tri_raw  = 1'b1;
          corner_a = older_q;
          corner_b = newer_q;
          phase_d  = '0;
        end else begin
          phase_d = phase_q + PHASE_BITS'(1);
        end
      end
      PRIM_STRIP: begin
        if (seen_q == SEEN_BITS'(2)) begin
          tri_raw  = 1'b1;
          corner_a = parity_q ? newer_q : older_q;
          corner_b = parity_q ? older_q : newer_q;
          parity_d = ~parity_q;
        end
      end
      PRIM_FAN: begin
        if (seen_q == SEEN_BITS'(2)) begin
          tri_raw  = 1'b1;
          corner_a = anchor_eff;
          corner_b = newer_q;
        end
      end
      default: begin
        tri_raw = 1'b0;
      end
    endcase
  end

  assign tri_ok = tri_raw && mat_ok && (corner_a != corner_b)
                  && (corner_b != vertex_index_i) && (vertex_index_i != corner_a);

  assign group_after = tri_ok ? sat_add(group_cnt_q, COUNT_BITS'(3)) : group_cnt_q;
  assign rec_ok      = group_end_i && (group_after != '0) && mat_ok;
  assign merge       = prev_valid_q && (prev_mat_q == material_id_i);
  assign rec_base    = merge ? prev_base_q : total_cnt_q;
  assign rec_cnt     = merge ? sat_add(prev_cnt_q, group_after) : group_after;

  always_comb begin
    tri_r          = '0;
    tri_r.kind     = KIND_TRIANGLE;
    tri_r.corner_a = corner_a;
    tri_r.corner_b = corner_b;
    tri_r.corner_c = vertex_index_i;
    tri_r.last     = ~rec_ok;

    rec_r          = '0;
    rec_r.kind     = KIND_RECORD;
    rec_r.material = material_id_i;
    rec_r.base     = rec_base;
    rec_r.count    = rec_cnt;
    rec_r.merged   = merge;
    rec_r.last     = 1'b1;

    first_r  = tri_ok ? tri_r : rec_r;
    second_r = rec_r;
  end

  assign push_o.first  = take_i && (tri_ok || rec_ok);
  assign push_o.second = take_i && tri_ok && rec_ok;
  assign first_o       = first_r;
  assign second_o      = second_r;

  always_comb begin
    anchor_d     = anchor_eff;
    older_d      = newer_q;
    newer_d      = vertex_index_i;
    seen_d       = (seen_q == SEEN_BITS'(2)) ? seen_q : seen_q + SEEN_BITS'(1);
    group_cnt_d  = group_after;
    total_cnt_d  = total_cnt_q;
    prev_valid_d = prev_valid_q;
    prev_mat_d   = prev_mat_q;
    prev_base_d  = prev_base_q;
    prev_cnt_d   = prev_cnt_q;
    if (rec_ok) begin
      prev_valid_d = 1'b1;
      prev_mat_d   = material_id_i;
      prev_base_d  = rec_base;
      prev_cnt_d   = rec_cnt;
    end
    if (group_end_i) begin
      total_cnt_d = sat_add(total_cnt_q, group_after);
      anchor_d    = '0;
      older_d     = '0;
      newer_d     = '0;
      seen_d      = '0;
      group_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q     <= '0;
      older_q      <= '0;
      newer_q      <= '0;
      phase_q      <= '0;
      parity_q     <= 1'b0;
      seen_q       <= '0;
      group_cnt_q  <= '0;
      total_cnt_q  <= '0;
      prev_valid_q <= 1'b0;
      prev_mat_q   <= '0;
      prev_base_q  <= '0;
      prev_cnt_q   <= '0;
    end else if (take_i) begin
      anchor_q     <= anchor_d;
      older_q      <= older_d;
      newer_q      <= newer_d;
      phase_q      <= group_end_i ? '0 : phase_d;
      parity_q     <= group_end_i ? 1'b0 : parity_d;
      seen_q       <= seen_d;
      group_cnt_q  <= group_cnt_d;
      total_cnt_q  <= total_cnt_d;
      prev_valid_q <= prev_valid_d;
      prev_mat_q   <= prev_mat_d;
      prev_base_q  <= prev_base_d;
      prev_cnt_q   <= prev_cnt_d;
    end
  end

endmodule

FILE: rtl/p2tl_out_fifo.sv
// result queue taking up to two results per cycle and giving one
module p2tl_out_fifo #(
  parameter int unsigned WIDTH = 120
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  p2tl_pkg::push_t  push_i,
  input  logic [WIDTH-1:0] first_i,
  input  logic [WIDTH-1:0] second_i,
  input  logic             pop_i,
  output logic             room_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);
  import p2tl_pkg::*;

  localparam int unsigned Depth    = 4;
  localparam int unsigned PtrBits  = $clog2(Depth);
  localparam int unsigned CntBits  = $clog2(Depth + 1);

  logic [WIDTH-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic [CntBits-1:0] n_push;
  logic               do_pop;

  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign room_o  = count_q <= CntBits'(Depth - 2);
  assign do_pop  = pop_i && valid_o;
  assign n_push  = CntBits'(push_i.first) + CntBits'(push_i.second);

  assign wr_ptr_d = wr_ptr_q + PtrBits'(n_push);
  assign rd_ptr_d = rd_ptr_q + PtrBits'(do_pop);
  assign count_d  = count_q + n_push - CntBits'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= first_i;
    end
    if (push_i.second) begin
      mem_q[wr_ptr_q + PtrBits'(1)] <= second_i;
    end
  end

endmodule

FILE: rtl/primitive_to_triangle_list.sv
// top level: index stream in, triangle list triangles and group records out
//
// input channel: one vertex index per request with its primitive type (list,
// strip, fan), material and an end-of-group flag. output channel: one result
// per request, either a triangle (three corners) or a group record (material,
// base, count, merged flag); run_last marks the final result of an index.
// an index is registered at acceptance and processed once the queue has
// room; its results are then written into a four-entry result queue, whose
// head drives the output.
// one index is taken every cycle while the queue holds two or fewer results,
// so the sustained rate is one index per cycle; an index giving both a
// triangle and a record adds one result, which the queue absorbs.
// when the receiver stalls the queue fills and the input register holds its
// request, raising in_stall_o until space frees up; output payload is stable
// while stalled. reset clears the assembly window, group and total counters,
// the previous record and the queue; nothing is emitted until indices arrive.
module primitive_to_triangle_list #(
  parameter int unsigned INDEX_BITS   = 16,
  parameter int unsigned COUNT_BITS   = 24,
  parameter int unsigned MAX_MATERIAL = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [INDEX_BITS-1:0]          vertex_index_i,
  input  logic [p2tl_pkg::TYPE_BITS-1:0] prim_type_i,
  input  logic [p2tl_pkg::MAT_BITS-1:0]  material_id_i,
  input  logic                           group_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           result_kind_o,
  output logic [INDEX_BITS-1:0]          corner_a_o,
  output logic [INDEX_BITS-1:0]          corner_b_o,
  output logic [INDEX_BITS-1:0]          corner_c_o,
  output logic [p2tl_pkg::MAT_BITS-1:0]  record_material_o,
  output logic [COUNT_BITS-1:0]          record_base_o,
  output logic [COUNT_BITS-1:0]          record_count_o,
  output logic                           record_merged_o,
  output logic                           run_last_o
);
  import p2tl_pkg::*;

  localparam int unsigned ResBits = 3 * INDEX_BITS + MAT_BITS + 2 * COUNT_BITS + 3;

  typedef struct packed {
    logic                  kind;
    logic [INDEX_BITS-1:0] corner_a;
    logic [INDEX_BITS-1:0] corner_b;
    logic [INDEX_BITS-1:0] corner_c;
    logic [MAT_BITS-1:0]   material;
    logic [COUNT_BITS-1:0] base;
    logic [COUNT_BITS-1:0] count;
    logic                  merged;
    logic                  last;
  } res_t;

  logic                  in_valid_q;
  logic [INDEX_BITS-1:0] index_q;
  logic [TYPE_BITS-1:0]  type_q;
  logic [MAT_BITS-1:0]   mat_q;
  logic                  end_q;
  logic                  room, take, accept;
  push_t                 push;
  logic [ResBits-1:0]    first_res, second_res, head_res;
  res_t                  head;

  assign take       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept || take) begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      index_q <= vertex_index_i;
      type_q  <= prim_type_i;
      mat_q   <= material_id_i;
      end_q   <= group_end_i;
    end
  end

  p2tl_assemble #(
    .INDEX_BITS   (INDEX_BITS),
    .COUNT_BITS   (COUNT_BITS),
    .MAX_MATERIAL (MAX_MATERIAL)
  ) u_assemble (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .vertex_index_i (index_q),
    .prim_type_i    (type_q),
    .material_id_i  (mat_q),
    .group_end_i    (end_q),
    .push_o         (push),
    .first_o        (first_res),
    .second_o       (second_res)
  );

  p2tl_out_fifo #(
    .WIDTH (ResBits)
  ) u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (first_res),
    .second_i (second_res),
    .pop_i    (!out_stall_i),
    .room_o   (room),
    .valid_o  (out_valid_o),
    .head_o   (head_res)
  );

  assign head              = head_res;
  assign result_kind_o     = head.kind;
  assign corner_a_o        = head.corner_a;
  assign corner_b_o        = head.corner_b;
  assign corner_c_o        = head.corner_c;
  assign record_material_o = head.material;
  assign record_base_o     = head.base;
  assign record_count_o    = head.count;
  assign record_merged_o   = head.merged;
  assign run_last_o        = head.last;

  // a group record is always the final result of its index
  a_record_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_RECORD) |-> run_last_o)
    else $error("group record without run_last");

  // triangles leaving the block are never degenerate
  a_tri_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_TRIANGLE) |->
      (corner_a_o != corner_b_o && corner_b_o != corner_c_o && corner_c_o != corner_a_o))
    else $error("degenerate triangle emitted");

  // record fields stay zero on triangles
  a_tri_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_TRIANGLE) |->
      (record_count_o == '0 && !record_merged_o && record_material_o == '0))
    else $error("triangle carries record fields");

  // a stalled input request is held in the input register
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("stalled request lost");

endmodule

FILE: test/tb.sv
// testbench for the primitive to triangle list converter
module tb;
  import p2tl_pkg::*;

  localparam int unsigned IDX_W          = 16;
  localparam int unsigned CNT_W          = 24;
  localparam int unsigned MAT_LIMIT      = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam logic [TYPE_BITS-1:0] PRIM_NONE = 2'd3;

  typedef struct {
    logic                 kind;
    logic [IDX_W-1:0]     corner_a;
    logic [IDX_W-1:0]     corner_b;
    logic [IDX_W-1:0]     corner_c;
    logic [MAT_BITS-1:0]  material;
    logic [CNT_W-1:0]     base;
    logic [CNT_W-1:0]     count;
    logic                 merged;
    logic                 last;
  } tri_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [IDX_W-1:0]     vertex_index_i = '0;
  logic [TYPE_BITS-1:0] prim_type_i = PRIM_LIST;
  logic [MAT_BITS-1:0]  material_id_i = '0;
  logic                 group_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 result_kind_o;
  logic [IDX_W-1:0]     corner_a_o;
  logic [IDX_W-1:0]     corner_b_o;
  logic [IDX_W-1:0]     corner_c_o;
  logic [MAT_BITS-1:0]  record_material_o;
  logic [CNT_W-1:0]     record_base_o;
  logic [CNT_W-1:0]     record_count_o;
  logic                 record_merged_o;
  logic                 run_last_o;

  tri_result_t pending_results[$];
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_idle_pct = 29;
  int unsigned out_idle_pct = 29;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  // assembly window, group counters and last record as the block should hold them
  logic [IDX_W-1:0]      anchor_idx;
  logic [IDX_W-1:0]      win_older;
  logic [IDX_W-1:0]      win_newer;
  logic [PHASE_BITS-1:0] list_pos;
  logic                  strip_odd;
  logic [SEEN_BITS-1:0]  seen_cnt;
  logic [CNT_W-1:0]      group_count;
  logic [CNT_W-1:0]      total_count;
  logic                  rec_valid;
  logic [MAT_BITS-1:0]   rec_material;
  logic [CNT_W-1:0]      rec_base;
  logic [CNT_W-1:0]      rec_count;

  primitive_to_triangle_list uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .vertex_index_i    (vertex_index_i),
    .prim_type_i       (prim_type_i),
    .material_id_i     (material_id_i),
    .group_end_i       (group_end_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .corner_a_o        (corner_a_o),
    .corner_b_o        (corner_b_o),
    .corner_c_o        (corner_c_o),
    .record_material_o (record_material_o),
    .record_base_o     (record_base_o),
    .record_count_o    (record_count_o),
    .record_merged_o   (record_merged_o),
    .run_last_o        (run_last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [CNT_W-1:0] count_add(input logic [CNT_W-1:0] x,
                                                 input logic [CNT_W-1:0] y);
    logic [CNT_W:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

  function automatic void clear_group();
    anchor_idx  = '0;
    win_older   = '0;
    win_newer   = '0;
    list_pos    = '0;
    strip_odd   = 1'b0;
    seen_cnt    = '0;
    group_count = '0;
  endfunction

  function automatic void reset_assembly();
    clear_group();
    total_count  = '0;
    rec_valid    = 1'b0;
    rec_material = '0;
    rec_base     = '0;
    rec_count    = '0;
  endfunction

  function automatic void assemble_index(input logic [IDX_W-1:0] idx,
                                         input logic [TYPE_BITS-1:0] ptype,
                                         input logic [MAT_BITS-1:0] mat,
                                         input logic gend);
    tri_result_t      res[2];
    int               n;
    logic             tri_ok;
    logic             mat_ok;
    logic [IDX_W-1:0] ca;
    logic [IDX_W-1:0] cb;
    n      = 0;
    tri_ok = 1'b0;
    ca     = '0;
    cb     = '0;
    mat_ok = mat <= MAT_LIMIT;
    if (seen_cnt == 0) anchor_idx = idx;
    case (ptype)
      PRIM_LIST: begin
        if (list_pos == 2) begin
          tri_ok   = 1'b1;
          ca       = win_older;
          cb       = win_newer;
          list_pos = '0;
        end else begin
          list_pos = list_pos + 1'b1;
        end
      end
      PRIM_STRIP: begin
        if (seen_cnt >= 2) begin
          tri_ok    = 1'b1;
          ca        = strip_odd ? win_newer : win_older;
          cb        = strip_odd ? win_older : win_newer;
          strip_odd = ~strip_odd;
        end
      end
      PRIM_FAN: begin
        if (seen_cnt >= 2) begin
          tri_ok = 1'b1;
          ca     = anchor_idx;
          cb     = win_newer;
        end
      end
      default: ;
    endcase
    // degenerate triangles and bad materials give nothing
    if (ca == cb || cb == idx || idx == ca) tri_ok = 1'b0;
    if (!mat_ok) tri_ok = 1'b0;
    win_older = win_newer;
    win_newer = idx;
    if (seen_cnt < 2) seen_cnt = seen_cnt + 1'b1;
    if (tri_ok) begin
      res[n] = '{KIND_TRIANGLE, ca, cb, idx, '0, '0, '0, 1'b0, 1'b0};
      group_count = count_add(group_count, CNT_W'(3));
      n++;
    end
    if (gend) begin
      if (group_count != 0 && mat_ok) begin
        res[n] = '{KIND_RECORD, '0, '0, '0, mat, '0, '0, 1'b0, 1'b0};
        if (rec_valid && rec_material == mat) begin
          rec_count     = count_add(rec_count, group_count);
          res[n].merged = 1'b1;
        end else begin
          rec_valid    = 1'b1;
          rec_material = mat;
          rec_base     = total_count;
          rec_count    = group_count;
        end
        res[n].base  = rec_base;
        res[n].count = rec_count;
        n++;
      end
      total_count = count_add(total_count, group_count);
      clear_group();
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_results.insert(pending_results.size(), res[k]);
  endfunction

  task automatic send_index(input logic [IDX_W-1:0] idx, input logic [TYPE_BITS-1:0] ptype,
                            input logic [MAT_BITS-1:0] mat, input logic gend);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    vertex_index_i <= idx;
    prim_type_i    <= ptype;
    material_id_i  <= mat;
    group_end_i    <= gend;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    assemble_index(idx, ptype, mat, gend);
    items_sent++;
  endtask

  function automatic logic [MAT_BITS-1:0] pick_material();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return MAT_BITS'($urandom_range(3));
    if (roll < 80) return MAT_BITS'($urandom_range(MAT_LIMIT));
    if (roll < 90) return MAT_BITS'(MAT_LIMIT);
    return MAT_BITS'($urandom_range(2047, MAT_LIMIT + 1));
  endfunction

  // tidy groups keep type and material; the others change them and end at random
  task automatic random_group(input bit tidy);
    int unsigned          len;
    int unsigned          i;
    bit                   narrow;
    logic [TYPE_BITS-1:0] ptype;
    logic [MAT_BITS-1:0]  mat;
    logic [IDX_W-1:0]     idx;
    logic                 gend;
    len    = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    ptype  = tidy ? TYPE_BITS'($urandom_range(2)) : TYPE_BITS'($urandom_range(3));
    mat    = pick_material();
    narrow = $urandom_range(3) == 0;
    for (i = 0; i < len; i++) begin
      idx  = narrow ? IDX_W'($urandom_range(7)) : IDX_W'($urandom);
      gend = (i == len - 1);
      if (!tidy) begin
        if ($urandom_range(3) == 0) ptype = TYPE_BITS'($urandom_range(3));
        if ($urandom_range(7) == 0) mat = pick_material();
        if ($urandom_range(5) == 0) gend = 1'b1;
      end
      send_index(idx, ptype, mat, gend);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      err_count++;
    end
  endtask

  task automatic check_result();
    tri_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with no request pending: kind %0d", result_kind_o);
      err_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("result_kind", want.kind, result_kind_o);
      compare_field("corner_a", want.corner_a, corner_a_o);
      compare_field("corner_b", want.corner_b, corner_b_o);
      compare_field("corner_c", want.corner_c, corner_c_o);
      compare_field("record_material", want.material, record_material_o);
      compare_field("record_base", want.base, record_base_o);
      compare_field("record_count", want.count, record_count_o);
      compare_field("record_merged", want.merged, record_merged_o);
      compare_field("run_last", want.last, run_last_o);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      if (hold_requests != hold_served && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= $urandom_range(99) < out_idle_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_directed();
    // list with extreme indices, then an incomplete triple at group end
    send_index(16'd0, PRIM_LIST, 11'd0, 1'b0);
    send_index(16'hffff, PRIM_LIST, 11'd0, 1'b0);
    send_index(16'd1, PRIM_LIST, 11'd0, 1'b0);
    send_index(16'd2, PRIM_LIST, 11'd0, 1'b0);
    send_index(16'd3, PRIM_LIST, 11'd0, 1'b1);
    // strip with the same material merges, odd triangle swapped
    send_index(16'd10, PRIM_STRIP, 11'd0, 1'b0);
    send_index(16'd11, PRIM_STRIP, 11'd0, 1'b0);
    send_index(16'd12, PRIM_STRIP, 11'd0, 1'b0);
    send_index(16'd13, PRIM_STRIP, 11'd0, 1'b1);
    // fan at the top material with a degenerate triangle
    send_index(16'd5, PRIM_FAN, 11'd1024, 1'b0);
    send_index(16'd6, PRIM_FAN, 11'd1024, 1'b0);
    send_index(16'd7, PRIM_FAN, 11'd1024, 1'b0);
    send_index(16'd7, PRIM_FAN, 11'd1024, 1'b0);
    send_index(16'd8, PRIM_FAN, 11'd1024, 1'b1);
    // material out of range: no triangle, no record
    send_index(16'd20, PRIM_STRIP, 11'd2047, 1'b0);
    send_index(16'd21, PRIM_STRIP, 11'd2047, 1'b0);
    send_index(16'd22, PRIM_STRIP, 11'd2047, 1'b1);
    // unused type, group without triangles
    send_index(16'd9, PRIM_NONE, 11'd5, 1'b1);
    // type and material change inside one group
    send_index(16'd30, PRIM_FAN, 11'd7, 1'b0);
    send_index(16'd31, PRIM_STRIP, 11'd7, 1'b0);
    send_index(16'd32, PRIM_STRIP, 11'd7, 1'b0);
    send_index(16'd33, PRIM_FAN, 11'd7, 1'b0);
    send_index(16'd34, PRIM_NONE, 11'd8, 1'b1);
  endtask

  task automatic test_tidy_groups(input int unsigned target);
    while (items_sent < target) random_group(1'b1);
  endtask

  task automatic test_noise(input int unsigned target);
    while (items_sent < target) begin
      random_group($urandom_range(2) == 0);
    end
  endtask

  task automatic test_output_hold();
    int unsigned stop_at;
    stop_at = items_sent + 40;
    in_idle_pct = 0;
    hold_requests++;
    while (items_sent < stop_at) random_group(1'b1);
    in_idle_pct = 29;
  endtask

  task automatic test_full_rate(input int unsigned target);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (items_sent < target) random_group(1'b1);
    in_idle_pct  = 29;
    out_idle_pct = 29;
  endtask

  initial begin
    reset_assembly();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_tidy_groups(600);
    test_noise(780);
    test_output_hold();
    test_full_rate(1000);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
